/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands for the unordered table block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge, ignored while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen at a rising clk edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* hdl/utisd_pkg.sv */
// ----------------------------------------------------------------------------
// utisd_pkg
// Field widths, command and status codes and the result record of the table.
// ----------------------------------------------------------------------------
`default_nettype none

package utisd_pkg;

    localparam int DEFAULT_CAPACITY = 128;

    localparam int ELEM_W     = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 7;
    localparam int USED_W     = 8;
    localparam int OUT_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [USED_W-1:0]   used;
        logic [POS_W-1:0]    pos;
    } result_t;

endpackage

`default_nettype wire

/* hdl/utisd_ram.sv */
// ----------------------------------------------------------------------------
// utisd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module utisd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/unordered_table_insert_search_delete_top.sv */
// ----------------------------------------------------------------------------
// unordered_table_insert_search_delete_top
// Unordered value table with append insert, lowest-index search and
// swap-with-last delete, kept in one RAM with a stored-value count.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser       | extra
//  s_*     | in  | [31:0] element                | [1:0] cmd   | -
//  m_*     | out | [6:0] position, [14:7] used   | [1:0] status| [15] zero
//
//  Insert, unused command, full or empty cases: from accept straight to the response state.
//  Search: the scan reads one RAM word a cycle until a hit or the last stored word.
//  Delete: scan, then a read of the last word, then its write into the found slot.
//  One request is worked at a time; a new one is taken while a result waits.
//  Reset clears the count, state and valid flags; the RAM holds no reset value and needs no pass.
// ----------------------------------------------------------------------------
`default_nettype none

module unordered_table_insert_search_delete_top
    import utisd_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [ELEM_W-1:0]     s_tdata,   // [31:0] element
    input  wire logic [CMD_W-1:0]      s_tuser,   // [1:0] cmd
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,   // [6:0] position, [14:7] entries_used
    output logic      [STATUS_W-1:0]   m_tuser    // [1:0] status
);

    `include "assert_macros.svh"

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_LAST  = 5'b00100,
        S_WRITE = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [ELEM_W-1:0] key_reg, key_next;
    logic              del_reg, del_next;
    logic [AW-1:0]     slot_reg, slot_next;
    result_t           res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    result_t           m_data_reg, m_data_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ELEM_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [ELEM_W-1:0] ram_rdata;

    logic              accept;
    logic              hit;
    logic [AW-1:0]     last_idx;

    utisd_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign hit      = cmp_valid_reg && (ram_rdata == key_reg);
    assign last_idx = AW'(count_reg - CW'(1));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        key_next       = key_reg;
        del_next       = del_reg;
        slot_next      = slot_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = scan_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next = s_tdata;
                    del_next = (s_tuser == CMD_DELETE);
                    unique case (s_tuser)
                        CMD_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                res_next = '{ST_FULL, USED_W'(count_reg), '0};
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = s_tdata;
                                count_next = count_reg + CW'(1);
                                res_next   = '{ST_OK, USED_W'(count_reg + CW'(1)),
                                               POS_W'(count_reg)};
                            end
                            state_next = S_RESP;
                        end
                        CMD_SEARCH, CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = (s_tuser == CMD_DELETE) ? ST_EMPTY
                                                                           : ST_MISSING;
                                res_next.used   = USED_W'(count_reg);
                                res_next.pos    = '0;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                scan_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_next   = '{ST_OK, USED_W'(count_reg), '0};
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // keep one read in flight, compare the word that just came back
                ram_re         = (scan_reg < count_reg) && !hit;
                cmp_valid_next = ram_re;
                cmp_idx_next   = scan_reg[AW-1:0];
                if (ram_re)
                begin
                    scan_next = scan_reg + CW'(1);
                end
                if (hit)
                begin
                    if (del_reg)
                    begin
                        slot_next  = cmp_idx_reg;
                        state_next = S_LAST;
                    end
                    else
                    begin
                        res_next   = '{ST_OK, USED_W'(count_reg), POS_W'(cmp_idx_reg)};
                        state_next = S_RESP;
                    end
                end
                else if (cmp_valid_reg && (cmp_idx_reg == last_idx))
                begin
                    res_next   = '{ST_MISSING, USED_W'(count_reg), '0};
                    state_next = S_RESP;
                end
            end
            S_LAST:
            begin
                ram_re     = 1'b1;
                ram_raddr  = last_idx;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // move the last word into the vacated slot
                ram_we     = 1'b1;
                ram_waddr  = slot_reg;
                ram_wdata  = ram_rdata;
                count_next = count_reg - CW'(1);
                res_next   = '{ST_OK, USED_W'(count_reg - CW'(1)), POS_W'(slot_reg)};
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        key_reg     <= key_next;
        del_reg     <= del_next;
        slot_reg    <= slot_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg.used, m_data_reg.pos};
    assign m_tuser  = m_data_reg.status;

    `ASSERT_CLK(a_accept_leaves_idle, (s_tvalid && s_tready) |=> (state_reg != S_IDLE),
        "request accepted but controller stayed idle")
    `ASSERT_CLK(a_count_change_src,
        !$stable(count_reg) |-> ($past(state_reg) == S_WRITE || $past(s_tvalid && s_tready)),
        "count changed outside insert or delete write")
    `ASSERT_CLK(a_delete_shrinks, (state_reg == S_WRITE) |=>
        (count_reg == $past(count_reg) - CW'(1)),
        "delete write did not shrink the count by one")
    `ASSERT_CLK(a_result_from_resp, $rose(m_tvalid) |-> ($past(state_reg) == S_RESP),
        "result presented without passing the response state")

endmodule

`default_nettype wire
